@@ src/sorted_priority_queue_core_macros.svh @@
// Assertion helpers used by the queue core RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("queue check failed");
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;
  localparam int TAG_BITS = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // port field widths, fixed by the interface
  typedef logic [15:0] field_t;
  typedef logic [4:0]  fill_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef struct packed {
    logic vld;
    key_t key;
    tag_t tag;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
    tag_t tag;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ src/sorted_priority_queue_core.sv @@
// Sorted priority queue of spq_pkg::CAPACITY entries held in a row of cells,
// kept in ascending key order. An insert (op 0) places key and tag before the
// first larger key; an equal key is dropped with duplicate status and an
// insert into a full queue is refused with full status. A remove (op 1) pops
// the smallest entry or reports empty. Each result carries the head entry and
// fill count after the operation. One item is taken per clock cycle and its
// result appears in the output register on the next cycle: every cell compares
// its key with the new key in the same cycle and shifts one place left or
// right, so the queue state is ready for the following item straight away.
// A result still waiting for out_ready holds off the next item until its
// transfer.
`default_nettype none
`include "sorted_priority_queue_core_macros.svh"
module sorted_priority_queue_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [15:0] in_new_key,
  input  wire logic [15:0] in_new_tag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_removed_key,
  output logic [15:0]      out_removed_tag,
  output logic             out_head_valid,
  output logic [15:0]      out_head_key,
  output logic [15:0]      out_head_tag,
  output logic [4:0]       out_fill_count
);

  localparam int N = spq_pkg::CAPACITY;

  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    ent     [N];
  spq_pkg::entry_t    ent_nxt [N];
  logic [N-1:0]       lt;
  logic [N-1:0]       eq;
  logic [N-1:0]       vld_vec;

  spq_pkg::cnt_t      count_r, count_nxt;
  logic               out_valid_r;
  spq_pkg::status_t   status_r, status_nxt;
  spq_pkg::field_t    rkey_r, rkey_nxt;
  spq_pkg::field_t    rtag_r, rtag_nxt;
  logic               hvld_r;
  spq_pkg::field_t    hkey_r, hkey_nxt;
  spq_pkg::field_t    htag_r, htag_nxt;
  spq_pkg::fill_t     fill_r;

  logic fire, is_rem, full, dup, empty;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_rem   = (in_op == spq_pkg::OP_REMOVE);
  assign full     = (count_r == spq_pkg::cnt_t'(N));
  assign empty    = (count_r == '0);
  assign dup      = |eq;

  assign ctl.ins = fire && !is_rem && !full && !dup;
  assign ctl.rem = fire && is_rem && !empty;
  assign ctl.key = spq_pkg::key_t'(in_new_key);
  assign ctl.tag = spq_pkg::tag_t'(in_new_tag);

  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t prev_e, next_e;
    logic            prev_l;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_l = lt[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_body
      assign next_e = ent[i+1];
    end
    spq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_ent (prev_e),
      .prev_lt  (prev_l),
      .next_ent (next_e),
      .ent      (ent[i]),
      .ent_nxt  (ent_nxt[i]),
      .lt       (lt[i]),
      .eq       (eq[i])
    );
    assign vld_vec[i] = ent[i].vld;
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    rkey_nxt   = '0;
    rtag_nxt   = '0;
    if (is_rem) begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        rkey_nxt  = spq_pkg::field_t'(ent[0].key);
        rtag_nxt  = spq_pkg::field_t'(ent[0].tag);
        count_nxt = count_r - 1'b1;
      end
    end else if (full) begin
      status_nxt = spq_pkg::ST_FULL;
    end else if (dup) begin
      status_nxt = spq_pkg::ST_DUP;
    end else begin
      count_nxt = count_r + 1'b1;
    end
    hkey_nxt = ent_nxt[0].vld ? spq_pkg::field_t'(ent_nxt[0].key) : '0;
    htag_nxt = ent_nxt[0].vld ? spq_pkg::field_t'(ent_nxt[0].tag) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      rkey_r   <= rkey_nxt;
      rtag_r   <= rtag_nxt;
      hvld_r   <= ent_nxt[0].vld;
      hkey_r   <= hkey_nxt;
      htag_r   <= htag_nxt;
      fill_r   <= spq_pkg::fill_t'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_removed_key = rkey_r;
  assign out_removed_tag = rtag_r;
  assign out_head_valid  = hvld_r;
  assign out_head_key    = hkey_r;
  assign out_head_tag    = htag_r;
  assign out_fill_count  = fill_r;

  `SPQ_ASSERT(a_count_matches_cells, $countones(vld_vec) == int'(count_r))
  `SPQ_ASSERT(a_count_bound, count_r <= spq_pkg::cnt_t'(N))
  `SPQ_ASSERT(a_head_consistent, !out_valid_r || (hvld_r == (fill_r != '0)))
  `SPQ_ASSERT_NEXT(a_insert_grows, ctl.ins, count_r == $past(count_r) + 1'b1)
  `SPQ_ASSERT_NEXT(a_remove_shrinks, ctl.rem, count_r == $past(count_r) - 1'b1)

endmodule
`default_nettype wire

@@ src/spq_cell.sv @@
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire spq_pkg::entry_t    prev_ent,
  input  wire logic               prev_lt,
  input  wire spq_pkg::entry_t    next_ent,
  output spq_pkg::entry_t         ent,
  output spq_pkg::entry_t         ent_nxt,
  output logic                    lt,
  output logic                    eq
);

  logic          vld_r;
  spq_pkg::key_t key_r;
  spq_pkg::tag_t tag_r;

  assign ent.vld = vld_r;
  assign ent.key = key_r;
  assign ent.tag = tag_r;

  assign lt = vld_r && (key_r < ctl.key);
  assign eq = vld_r && (key_r == ctl.key);

  always_comb begin
    ent_nxt = ent;
    if (ctl.rem) begin
      // advance towards the head
      ent_nxt = next_ent;
    end else if (ctl.ins && !lt) begin
      if (prev_lt) begin
        ent_nxt.vld = 1'b1;
        ent_nxt.key = ctl.key;
        ent_nxt.tag = ctl.tag;
      end else begin
        ent_nxt = prev_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ent_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= ent_nxt.key;
    tag_r <= ent_nxt.tag;
  end

endmodule
`default_nettype wire

@@ tb/tb_sorted_priority_queue_core.sv @@
`default_nettype none
module tb_sorted_priority_queue_core;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 35;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    spq_pkg::status_t status;
    spq_pkg::field_t  removed_key;
    spq_pkg::field_t  removed_tag;
    logic             head_valid;
    spq_pkg::field_t  head_key;
    spq_pkg::field_t  head_tag;
    spq_pkg::fill_t   fill_count;
  } queue_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [15:0] in_new_key = '0;
  logic [15:0] in_new_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_removed_key;
  logic [15:0] out_removed_tag;
  logic        out_head_valid;
  logic [15:0] out_head_key;
  logic [15:0] out_head_tag;
  logic [4:0]  out_fill_count;

  // shadow copy of the sorted store
  spq_pkg::key_t shadow_keys [spq_pkg::CAPACITY];
  spq_pkg::tag_t shadow_tags [spq_pkg::CAPACITY];
  int unsigned   shadow_fill = 0;

  queue_result_t awaited_results [$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            src_idle_on = 1'b1;
  bit            sink_stall_on = 1'b1;

  sorted_priority_queue_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_new_key      (in_new_key),
    .in_new_tag      (in_new_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_removed_key (out_removed_key),
    .out_removed_tag (out_removed_tag),
    .out_head_valid  (out_head_valid),
    .out_head_key    (out_head_key),
    .out_head_tag    (out_head_tag),
    .out_fill_count  (out_fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic queue_result_t apply_queue_op(spq_pkg::op_t op, spq_pkg::field_t key,
                                                   spq_pkg::field_t tag);
    queue_result_t r;
    spq_pkg::key_t k;
    spq_pkg::tag_t t;
    int            pos;
    k = key[spq_pkg::KEY_BITS-1:0];
    t = tag[spq_pkg::TAG_BITS-1:0];
    r = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (shadow_fill >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_fill && shadow_keys[pos] < k) pos++;
        if (pos < shadow_fill && shadow_keys[pos] == k) begin
          r.status = spq_pkg::ST_DUP;
        end else begin
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_tags[i] = shadow_tags[i-1];
          end
          shadow_keys[pos] = k;
          shadow_tags[pos] = t;
          shadow_fill++;
          r.status = spq_pkg::ST_OK;
        end
      end
    end else if (shadow_fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.status      = spq_pkg::ST_OK;
      r.removed_key = spq_pkg::field_t'(shadow_keys[0]);
      r.removed_tag = spq_pkg::field_t'(shadow_tags[0]);
      for (int i = 1; i < shadow_fill; i++) begin
        shadow_keys[i-1] = shadow_keys[i];
        shadow_tags[i-1] = shadow_tags[i];
      end
      shadow_fill--;
    end
    if (shadow_fill > 0) begin
      r.head_valid = 1'b1;
      r.head_key   = spq_pkg::field_t'(shadow_keys[0]);
      r.head_tag   = spq_pkg::field_t'(shadow_tags[0]);
    end
    r.fill_count = spq_pkg::fill_t'(shadow_fill);
    return r;
  endfunction

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready)
        awaited_results.push_back(apply_queue_op(spq_pkg::op_t'(in_op), in_new_key,
                                                 in_new_tag));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result: st=%0d rk=%h rt=%h hv=%b hk=%h ht=%h fc=%0d",
                     out_status, out_removed_key, out_removed_tag, out_head_valid,
                     out_head_key, out_head_tag, out_fill_count);
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_status !== exp_r.status || out_removed_key !== exp_r.removed_key ||
              out_removed_tag !== exp_r.removed_tag ||
              out_head_valid !== exp_r.head_valid || out_head_key !== exp_r.head_key ||
              out_head_tag !== exp_r.head_tag || out_fill_count !== exp_r.fill_count) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $write("mismatch: exp st=%0d rk=%h rt=%h hv=%b hk=%h ht=%h fc=%0d",
                     exp_r.status, exp_r.removed_key, exp_r.removed_tag,
                     exp_r.head_valid, exp_r.head_key, exp_r.head_tag,
                     exp_r.fill_count);
              $display(" | got st=%0d rk=%h rt=%h hv=%b hk=%h ht=%h fc=%0d",
                       out_status, out_removed_key, out_removed_tag,
                       out_head_valid, out_head_key, out_head_tag, out_fill_count);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= sink_stall_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid is left high on return; the next call or the caller lowers it
  task automatic send_item(spq_pkg::op_t op, spq_pkg::field_t key, spq_pkg::field_t tag);
    if (src_idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_new_key <= key;
    in_new_tag <= tag;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic send_random_item(int insert_pct);
    spq_pkg::op_t    op;
    spq_pkg::field_t key;
    op = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
    case ($urandom_range(9))
      0, 1: key = (shadow_fill > 0)
                  ? spq_pkg::field_t'(shadow_keys[$urandom_range(shadow_fill-1)])
                  : spq_pkg::field_t'($urandom);
      2, 3, 4: key = spq_pkg::field_t'($urandom_range(63));
      default: key = spq_pkg::field_t'($urandom);
    endcase
    send_item(op, key, spq_pkg::field_t'($urandom));
  endtask

  task automatic test_directed_cases();
    spq_pkg::field_t k;
    send_item(spq_pkg::OP_REMOVE, 16'h0000, 16'h0000);
    send_item(spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_item(spq_pkg::OP_INSERT, 16'h0000, 16'h0000);
    send_item(spq_pkg::OP_INSERT, 16'hFFFF, 16'h1234);
    send_item(spq_pkg::OP_INSERT, 16'h0000, 16'hABCD);
    // fill to capacity with scattered keys, landing in the middle of the list
    for (int i = 1; i <= 14; i++) begin
      k = spq_pkg::field_t'(((i * 7) % 15) * 16'h1111);
      send_item(spq_pkg::OP_INSERT, k, ~k ^ spq_pkg::field_t'(i));
    end
    send_item(spq_pkg::OP_INSERT, 16'h8000, 16'h5555);
    // full takes priority over a duplicate key
    send_item(spq_pkg::OP_INSERT, 16'h7777, 16'hAAAA);
    repeat (3) send_item(spq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF);
  endtask

  // pick fill, drain and balanced phases at random so the queue swings full to empty
  task automatic test_random_traffic(int n_items);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      send_random_item(insert_pct);
    end
  endtask

  task automatic test_quiet_stretch(int n_items);
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    test_random_traffic(n_items);
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  task automatic test_hold_until_drained();
    repeat (12) send_random_item(70);
    wait_until_drained();
    repeat (12) send_random_item(30);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(300);
    test_hold_until_drained();
    test_quiet_stretch(150);
    test_random_traffic(300);
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
tb/tb_sorted_priority_queue_core.sv
